// ===== src/assert_macros.svh =====
// Assertion helpers for the symmetry lookup checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is asserted.
`define SSL_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("symmetry lookup assertion failed");

// If cond holds, sig keeps its value into the next cycle.
`define SSL_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error("symmetry lookup hold check failed");

`endif

// ===== src/ssl_pkg.sv =====
`timescale 1ns / 1ps
package ssl_pkg;
	localparam int TABLE_DEPTH = 1024;
	localparam int MAX_RADIX = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int CODE_W = 20;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = $clog2(MAX_RADIX);
	localparam int NUM_VIRTUAL = 4;
	localparam int SEL_W = $clog2(NUM_VIRTUAL);
	localparam int DIV_STEPS = CODE_W / 2;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = CNT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b1;

	typedef enum logic [2:0] {
		OP_LOAD     = 3'd0,
		OP_IDENTITY = 3'd1,
		OP_ROTATE   = 3'd2,
		OP_HREFL    = 3'd3,
		OP_VREFL    = 3'd4,
		OP_DIAG     = 3'd5,
		OP_ANTIDIAG = 3'd6,
		OP_SPARE    = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_DIG, ST_MUL, ST_CHK, ST_MID, ST_LO, ST_HI, ST_FIN
	} state_t;

	typedef enum logic [1:0] {RD_MID, RD_LO, RD_HI} rd_sel_t;

	typedef enum logic [2:0] {RES_NONE, RES_MID, RES_LO, RES_HI, RES_MISS} res_sel_t;

	typedef struct packed {
		logic             cap;
		logic             div_step;
		logic             dig_store;
		logic             mul_step;
		logic             srch_init;
		logic             cmp_upd;
		logic [SEL_W-1:0] sel;
		rd_sel_t          rd_sel;
		res_sel_t         res_sel;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic in_load;
		logic empty;
		logic wide;
		logic eq;
	} stat_t;
endpackage

// ===== src/spin_state_symmetry_lookup.sv =====
`timescale 1ns / 1ps
// Symmetry lookup over a sorted table of five-digit single-radix state codes.
// Input channel (in_valid/in_ready): opcode, load_slot, state_code. A load
//   transaction writes one table entry; a query maps the code by one of the
//   lattice symmetries and binary-searches the table for the result.
// Output channel (out_valid/out_ready): result_index, found, mapped_code,
//   one transaction per input transaction, in order.
// Config: cfg_we/cfg_index/cfg_data; index 0 radix, 1 table_size. Write
//   only while the block is idle.
// Sequence: a load goes from idle straight to the hand-off. A query does
//   extraction of four digits (2-bit restoring divider), a multiply-add rebuild,
//   then a binary search on the table RAM's single read port (up to 10
//   probes), the final lo/hi check and the hand-off; an empty table skips
//   the search.
// Throughput: one transaction in flight; in_ready is high in idle only.
// Reset: arst_n clears control, sets radix 2 and table_size 0; the table
//   holds no defined contents until loaded.
// Stall: the result sits in an output register; the next transaction is
//   accepted and worked on, and waits at completion until the register frees.
module spin_state_symmetry_lookup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ssl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      opcode,
	input  logic [ssl_pkg::IDX_W-1:0]       load_slot,
	input  logic [ssl_pkg::CODE_W-1:0]      state_code,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ssl_pkg::CNT_W-1:0]       result_index,
	output logic                            found,
	output logic [ssl_pkg::CODE_W-1:0]      mapped_code
);
	ssl_pkg::cmd_t  cmd;
	ssl_pkg::stat_t stat;

	// Sequencer: divide, rebuild, search, hand off.
	ssl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Config registers, divider, rebuild, search bounds, table and result.
	ssl_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.load_slot    (load_slot),
		.state_code   (state_code),
		.cmd          (cmd),
		.stat         (stat),
		.result_index (result_index),
		.found        (found),
		.mapped_code  (mapped_code)
	);
endmodule

// ===== src/ssl_ram.sv =====
`timescale 1ns / 1ps
module ssl_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/ssl_datapath.sv =====
`timescale 1ns / 1ps
module ssl_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ssl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [2:0]                      opcode,
	input  logic [ssl_pkg::IDX_W-1:0]       load_slot,
	input  logic [ssl_pkg::CODE_W-1:0]      state_code,
	input  ssl_pkg::cmd_t                   cmd,
	output ssl_pkg::stat_t                  stat,
	output logic [ssl_pkg::CNT_W-1:0]       result_index,
	output logic                            found,
	output logic [ssl_pkg::CODE_W-1:0]      mapped_code
);
	logic [ssl_pkg::RADIX_W-1:0] radix_q;
	logic [ssl_pkg::CNT_W-1:0]   table_size_q;
	logic [ssl_pkg::RADIX_W-1:0] r_eff;
	logic [ssl_pkg::CNT_W-1:0]   n_eff;

	logic [2:0]                  op_q;
	logic [ssl_pkg::CODE_W-1:0]  w_q;
	logic [ssl_pkg::DIGIT_W-1:0] rem_q;
	logic [ssl_pkg::DIGIT_W-1:0] dig_q [ssl_pkg::NUM_VIRTUAL];
	logic [ssl_pkg::DIGIT_W-1:0] perm [ssl_pkg::NUM_VIRTUAL];
	logic [ssl_pkg::IDX_W-1:0]   lo_q, hi_q, mid;
	logic [ssl_pkg::CNT_W-1:0]   mid_sum;
	logic [ssl_pkg::CNT_W-1:0]   res_idx_q;
	logic                        res_found_q;

	logic [ssl_pkg::CODE_W-1:0]  w_div;
	logic [ssl_pkg::DIGIT_W-1:0] rem_div;
	logic [ssl_pkg::CODE_W+ssl_pkg::RADIX_W-1:0] prod;

	logic                        ram_we;
	logic [ssl_pkg::IDX_W-1:0]   raddr;
	logic [ssl_pkg::CODE_W-1:0]  rdata;

	// Effective configuration: radix clamped into 1..MAX_RADIX, size to depth.
	always_comb begin
		r_eff = radix_q;
		if (radix_q == '0) begin
			r_eff = ssl_pkg::RADIX_W'(1);
		end else if (radix_q > ssl_pkg::RADIX_W'(ssl_pkg::MAX_RADIX)) begin
			r_eff = ssl_pkg::RADIX_W'(ssl_pkg::MAX_RADIX);
		end
		n_eff = table_size_q;
		if (table_size_q > ssl_pkg::CNT_W'(ssl_pkg::TABLE_DEPTH)) begin
			n_eff = ssl_pkg::CNT_W'(ssl_pkg::TABLE_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q      <= ssl_pkg::RADIX_W'(2);
			table_size_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ssl_pkg::CFG_RADIX:      radix_q <= cfg_data[ssl_pkg::RADIX_W-1:0];
				ssl_pkg::CFG_TABLE_SIZE: table_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Restoring division, two quotient bits per cycle.
	always_comb begin
		logic [ssl_pkg::DIGIT_W:0] t;
		w_div   = w_q;
		rem_div = rem_q;
		for (int k = 0; k < 2; k++) begin
			t = {rem_div, w_div[ssl_pkg::CODE_W-1]};
			if (t >= r_eff) begin
				rem_div = ssl_pkg::DIGIT_W'(t - r_eff);
				w_div   = {w_div[ssl_pkg::CODE_W-2:0], 1'b1};
			end else begin
				rem_div = t[ssl_pkg::DIGIT_W-1:0];
				w_div   = {w_div[ssl_pkg::CODE_W-2:0], 1'b0};
			end
		end
	end

	// Digit order in dig_q: 0 down, 1 right, 2 up, 3 left.
	// perm gives the rebuild order: new left, up, right, down.
	always_comb begin
		perm[0] = dig_q[3];
		perm[1] = dig_q[2];
		perm[2] = dig_q[1];
		perm[3] = dig_q[0];
		case (op_q)
			ssl_pkg::OP_ROTATE: begin
				perm[0] = dig_q[2]; perm[1] = dig_q[1];
				perm[2] = dig_q[0]; perm[3] = dig_q[3];
			end
			ssl_pkg::OP_HREFL: begin
				perm[1] = dig_q[0]; perm[3] = dig_q[2];
			end
			ssl_pkg::OP_VREFL: begin
				perm[0] = dig_q[1]; perm[2] = dig_q[3];
			end
			ssl_pkg::OP_DIAG: begin
				perm[0] = dig_q[0]; perm[1] = dig_q[1];
				perm[2] = dig_q[2]; perm[3] = dig_q[3];
			end
			ssl_pkg::OP_ANTIDIAG: begin
				perm[0] = dig_q[2]; perm[1] = dig_q[3];
				perm[2] = dig_q[0]; perm[3] = dig_q[1];
			end
			default: ;
		endcase
	end

	assign prod    = w_q * r_eff;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[ssl_pkg::IDX_W:1];

	always_comb begin
		case (cmd.rd_sel)
			ssl_pkg::RD_LO: raddr = lo_q;
			ssl_pkg::RD_HI: raddr = hi_q;
			default:        raddr = mid;
		endcase
	end

	assign ram_we = cmd.cap && (opcode == ssl_pkg::OP_LOAD)
		&& ({1'b0, load_slot} < ssl_pkg::CNT_W'(ssl_pkg::TABLE_DEPTH));

	ssl_ram #(
		.WIDTH(ssl_pkg::CODE_W),
		.DEPTH(ssl_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (load_slot),
		.wdata (state_code),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q        <= opcode;
			w_q         <= state_code;
			rem_q       <= '0;
			res_idx_q   <= {1'b0, load_slot};
			res_found_q <= 1'b0;
		end else begin
			if (cmd.div_step) begin
				w_q   <= w_div;
				rem_q <= rem_div;
			end
			if (cmd.dig_store) begin
				dig_q[cmd.sel] <= rem_q;
				rem_q          <= '0;
			end
			if (cmd.mul_step) begin
				w_q <= prod[ssl_pkg::CODE_W-1:0] + ssl_pkg::CODE_W'(perm[cmd.sel]);
			end
			case (cmd.res_sel)
				ssl_pkg::RES_MID: begin res_idx_q <= {1'b0, mid};  res_found_q <= 1'b1; end
				ssl_pkg::RES_LO:  begin res_idx_q <= {1'b0, lo_q}; res_found_q <= 1'b1; end
				ssl_pkg::RES_HI:  begin res_idx_q <= {1'b0, hi_q}; res_found_q <= 1'b1; end
				ssl_pkg::RES_MISS: begin res_idx_q <= n_eff; res_found_q <= 1'b0; end
				default: ;
			endcase
		end
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= ssl_pkg::IDX_W'(n_eff - ssl_pkg::CNT_W'(1));
		end else if (cmd.cmp_upd) begin
			if (rdata < w_q) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.out_load) begin
			result_index <= res_idx_q;
			found        <= res_found_q;
			mapped_code  <= w_q;
		end
	end

	assign stat.in_load = (opcode == ssl_pkg::OP_LOAD);
	assign stat.empty   = (n_eff == '0);
	assign stat.wide    = (hi_q - lo_q) > ssl_pkg::IDX_W'(1);
	assign stat.eq      = (rdata == w_q);
endmodule

// ===== src/ssl_ctrl.sv =====
`timescale 1ns / 1ps
module ssl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  ssl_pkg::stat_t stat,
	output ssl_pkg::cmd_t  cmd
);
	ssl_pkg::state_t             state_q, state_d;
	logic [ssl_pkg::STEP_W-1:0]  cnt_q, cnt_d;
	logic [ssl_pkg::SEL_W-1:0]   dig_q, dig_d;
	logic                        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssl_pkg::ST_IDLE;
			cnt_q       <= '0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			dig_q   <= dig_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ssl_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		dig_d   = dig_q;
		cmd     = '0;
		cmd.rd_sel  = ssl_pkg::RD_MID;
		cmd.res_sel = ssl_pkg::RES_NONE;
		case (state_q)
			ssl_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					cnt_d   = '0;
					dig_d   = '0;
					state_d = stat.in_load ? ssl_pkg::ST_FIN : ssl_pkg::ST_DIV;
				end
			end
			ssl_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == ssl_pkg::STEP_W'(ssl_pkg::DIV_STEPS - 1)) begin
					state_d = ssl_pkg::ST_DIG;
				end
			end
			ssl_pkg::ST_DIG: begin
				cmd.dig_store = 1'b1;
				cmd.sel       = dig_q;
				cnt_d         = '0;
				dig_d         = dig_q + 1'b1;
				state_d = (dig_q == ssl_pkg::SEL_W'(ssl_pkg::NUM_VIRTUAL - 1))
					? ssl_pkg::ST_MUL : ssl_pkg::ST_DIV;
			end
			ssl_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.sel      = cnt_q[ssl_pkg::SEL_W-1:0];
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == ssl_pkg::STEP_W'(ssl_pkg::NUM_VIRTUAL - 1)) begin
					if (stat.empty) begin
						cmd.res_sel = ssl_pkg::RES_MISS;
						state_d     = ssl_pkg::ST_FIN;
					end else begin
						cmd.srch_init = 1'b1;
						state_d       = ssl_pkg::ST_CHK;
					end
				end
			end
			ssl_pkg::ST_CHK: begin
				if (stat.wide) begin
					cmd.rd_sel = ssl_pkg::RD_MID;
					state_d    = ssl_pkg::ST_MID;
				end else begin
					cmd.rd_sel = ssl_pkg::RD_LO;
					state_d    = ssl_pkg::ST_LO;
				end
			end
			ssl_pkg::ST_MID: begin
				if (stat.eq) begin
					cmd.res_sel = ssl_pkg::RES_MID;
					state_d     = ssl_pkg::ST_FIN;
				end else begin
					cmd.cmp_upd = 1'b1;
					state_d     = ssl_pkg::ST_CHK;
				end
			end
			ssl_pkg::ST_LO: begin
				if (stat.eq) begin
					cmd.res_sel = ssl_pkg::RES_LO;
					state_d     = ssl_pkg::ST_FIN;
				end else begin
					cmd.rd_sel = ssl_pkg::RD_HI;
					state_d    = ssl_pkg::ST_HI;
				end
			end
			ssl_pkg::ST_HI: begin
				cmd.res_sel = stat.eq ? ssl_pkg::RES_HI : ssl_pkg::RES_MISS;
				state_d     = ssl_pkg::ST_FIN;
			end
			ssl_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ssl_pkg::ST_IDLE;
				end
			end
			default: state_d = ssl_pkg::ST_IDLE;
		endcase
	end
endmodule

// ===== src/ssl_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [10:0] result_index,
	input logic        found
);
	`SSL_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`SSL_ASSERT_HOLD(a_idx_hold, clk, arst_n, out_valid && !out_ready, result_index)
	// a hit always points inside the table
	`SSL_ASSERT(a_hit_in_range, clk, arst_n, out_valid && found |-> !result_index[10])
	// a query never answers in the next cycle
	`SSL_ASSERT(a_query_latency, clk, arst_n, in_valid && in_ready && opcode != ssl_pkg::OP_LOAD && !out_valid |=> !out_valid)
endmodule

bind spin_state_symmetry_lookup ssl_checker u_ssl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.opcode       (opcode),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_index (result_index),
	.found        (found)
);
